FILE: sv/tedq_pkg.sv
// Package for the tensor element dequantizer: format codes, register indexes,
// float constants, pipeline stage structs and the fp16 widening function.
// Depends on nothing; every file but the checker imports it.
package tedq_pkg;

    localparam logic [2:0] FMT_FP32  = 3'd0;
    localparam logic [2:0] FMT_FP16  = 3'd1;
    localparam logic [2:0] FMT_UINT8 = 3'd2;
    localparam logic [2:0] FMT_INT8  = 3'd3;

    localparam logic [1:0] REG_FORMAT     = 2'd0;
    localparam logic [1:0] REG_ZERO_POINT = 2'd1;
    localparam logic [1:0] REG_SCALE      = 2'd2;

    localparam logic [31:0] EXP_ALL_ONES = 32'h7F80_0000;
    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN  = 32'h7FC0_0000;
    localparam logic [31:0] SCALE_RESET  = 32'h3F80_0000;
    localparam logic [7:0]  HALF_TO_SINGLE_BIAS = 8'd112;
    localparam logic [9:0]  HALF_MANT_MASK = 10'h3FF;
    localparam logic [4:0]  HALF_EXP_MASK  = 5'h1F;
    localparam logic [7:0]  SEXP_ALL_ONES  = 8'hFF;

    typedef struct packed {
        logic [2:0]        element_format;
        logic signed [8:0] zero_point;
        logic [31:0]       scale_bits;
    } tedq_cfg_t;

    // After decode: either a finished value or the operands of the product.
    typedef struct packed {
        logic        special;
        logic [31:0] value;
        logic        sign;
        logic [8:0]  mag;
        logic [7:0]  sexp;
        logic [23:0] sman;
    } tedq_s1_t;

    typedef struct packed {
        logic        special;
        logic [31:0] value;
        logic        sign;
        logic [7:0]  sexp;
        logic [32:0] prod;
    } tedq_s2_t;

    typedef struct packed {
        logic              special;
        logic [31:0]       value;
        logic              sign;
        logic [7:0]        sexp;
        logic [32:0]       prod;
        logic signed [5:0] rsh;
    } tedq_s3_t;

    // Exact fp16 to fp32 widening, subnormal inputs normalized.
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic        sgn;
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  msb;
        logic [20:0] t;
        logic [7:0]  ex;
        sgn = h[15];
        e   = h[14:10];
        m   = h[9:0] & HALF_MANT_MASK;
        msb = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (m[i])
                msb = 4'(i);
        end
        t  = {11'b0, m} << (4'd10 - msb);
        ex = 8'd103 + {4'b0, msb};
        if (e == 5'd0)
        begin
            if (m == 10'd0)
                widen_half = {sgn, 31'b0};
            else
                widen_half = {sgn, ex, t[9:0], 13'b0};
        end
        else if (e == HALF_EXP_MASK)
            widen_half = {sgn, EXP_ALL_ONES[30:23], m, 13'b0};
        else
            widen_half = {sgn, 8'({3'b0, e}) + HALF_TO_SINGLE_BIAS, m, 13'b0};
    endfunction

endpackage

FILE: sv/tedq_front.sv
// First pipeline stage: format decode, zero point subtraction and special cases.
// Depends on tedq_pkg.
module tedq_front
    import tedq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tedq_cfg_t   cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] raw_element,
    output logic        out_valid,
    input  logic        out_ready,
    output tedq_s1_t    out_data
);

    logic     valid_reg;
    tedq_s1_t data_reg;
    tedq_s1_t data_next;

    logic signed [9:0] q;
    logic signed [9:0] diff;
    logic signed [9:0] ndiff;
    logic [8:0]        mag;
    logic              sign;
    logic [7:0]        sexp;
    logic [22:0]       sfrac;

    always_comb
    begin
        if (cfg.element_format == FMT_INT8)
            q = $signed({{2{raw_element[7]}}, raw_element[7:0]});
        else
            q = $signed({2'b0, raw_element[7:0]});
        diff  = q - $signed({cfg.zero_point[8], cfg.zero_point});
        ndiff = -diff;
        mag   = diff[9] ? ndiff[8:0] : diff[8:0];
        sexp  = cfg.scale_bits[30:23];
        sfrac = cfg.scale_bits[22:0];
        sign  = cfg.scale_bits[31] ^ diff[9];

        data_next.special = 1'b1;
        data_next.value   = 32'd0;
        data_next.sign    = sign;
        data_next.mag     = mag;
        data_next.sexp    = (sexp == 8'd0) ? 8'd1 : sexp;
        data_next.sman    = {(sexp != 8'd0), sfrac};

        unique case (cfg.element_format) inside
            FMT_FP32:
                data_next.value = raw_element;
            FMT_FP16:
                data_next.value = widen_half(raw_element[15:0]);
            FMT_UINT8, FMT_INT8:
            begin
                if (sexp == SEXP_ALL_ONES)
                begin
                    if (sfrac != 23'd0)
                        data_next.value = cfg.scale_bits | QUIET_BIT;
                    else if (mag == 9'd0)
                        data_next.value = DEFAULT_NAN;
                    else
                        data_next.value = {sign, EXP_ALL_ONES[30:0]};
                end
                else
                    data_next.special = 1'b0;
            end
            default:
                data_next.value = 32'd0;
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

FILE: sv/tedq_mul.sv
// Second pipeline stage: 9 by 24 bit magnitude times scale significand.
// Depends on tedq_pkg.
module tedq_mul
    import tedq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  tedq_s1_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output tedq_s2_t out_data
);

    logic     valid_reg;
    tedq_s2_t data_reg;
    tedq_s2_t data_next;

    always_comb
    begin
        data_next.special = in_data.special;
        data_next.value   = in_data.value;
        data_next.sign    = in_data.sign;
        data_next.sexp    = in_data.sexp;
        data_next.prod    = 33'(in_data.mag) * 33'(in_data.sman);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

FILE: sv/tedq_norm.sv
// Third pipeline stage: leading one search on the product and the shift amount,
// clamped so that tiny results come out subnormal. Depends on tedq_pkg.
module tedq_norm
    import tedq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  tedq_s2_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output tedq_s3_t out_data
);

    logic     valid_reg;
    tedq_s3_t data_reg;
    tedq_s3_t data_next;

    logic [5:0]        len;
    logic signed [9:0] r_len;
    logic signed [9:0] r_floor;
    logic signed [9:0] r_sel;

    always_comb
    begin
        len = 6'd0;
        for (int i = 0; i < 33; i++)
        begin
            if (in_data.prod[i])
                len = 6'(i + 1);
        end
        r_len   = $signed({4'b0, len}) - 10'sd24;
        r_floor = 10'sd1 - $signed({2'b0, in_data.sexp});
        r_sel   = (r_len < r_floor) ? r_floor : r_len;

        data_next.special = in_data.special;
        data_next.value   = in_data.value;
        data_next.sign    = in_data.sign;
        data_next.sexp    = in_data.sexp;
        data_next.prod    = in_data.prod;
        data_next.rsh     = r_sel[5:0];
        // A zero product is a signed zero.
        if (!in_data.special && len == 6'd0)
        begin
            data_next.special = 1'b1;
            data_next.value   = {in_data.sign, 31'b0};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

FILE: sv/tedq_round.sv
// Fourth pipeline stage and output register: shift, round to nearest even,
// exponent and overflow handling, final packing. Depends on tedq_pkg.
module tedq_round
    import tedq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  tedq_s3_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value_bits
);

    logic        valid_reg;
    logic [31:0] value_reg;
    logic [31:0] value_next;

    logic signed [5:0] neg_r;
    logic signed [5:0] r_fin;
    logic [4:0]        lsh;
    logic [3:0]        rsh;
    logic [32:0]       shifted;
    logic [32:0]       mask;
    logic [32:0]       rem;
    logic [32:0]       half;
    logic [24:0]       rv;
    logic [24:0]       rv_n;
    logic              round_up;
    logic signed [9:0] be;

    always_comb
    begin
        neg_r   = -in_data.rsh;
        lsh     = neg_r[4:0];
        rsh     = in_data.rsh[3:0];
        shifted = in_data.prod >> rsh;
        mask    = (33'd1 << rsh) - 33'd1;
        rem     = in_data.prod & mask;
        half    = 33'd1 << (4'(rsh - 4'd1));
        round_up = 1'b0;
        if (in_data.rsh <= 6'sd0)
            rv = {1'b0, in_data.prod[23:0]} << lsh;
        else
        begin
            rv = shifted[24:0];
            round_up = (rem > half) || (rem == half && shifted[0]);
        end
        rv = rv + 25'(round_up);
        if (rv[24])
        begin
            rv_n  = rv >> 1;
            r_fin = in_data.rsh + 6'sd1;
        end
        else
        begin
            rv_n  = rv;
            r_fin = in_data.rsh;
        end
        be = $signed({2'b0, in_data.sexp}) + $signed({{4{r_fin[5]}}, r_fin});

        if (in_data.special)
            value_next = in_data.value;
        else if (!rv_n[23])
            value_next = {in_data.sign, 8'd0, rv_n[22:0]};
        else if (be >= 10'sd255)
            value_next = {in_data.sign, EXP_ALL_ONES[30:0]};
        else
            value_next = {in_data.sign, be[7:0], rv_n[22:0]};
    end

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign value_bits = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            value_reg <= value_next;
    end

endmodule

FILE: sv/tensor_element_dequantizer.sv
// An accepted request is registered in turn by the decode, product, normalize and round stages.
// Throughput: one element per cycle while out_ready is high; each of the four stages holds one element and
// takes a new one whenever it is empty or its result moves on, so bubbles close up.
// Reset (rst_n, asynchronous, active low) empties every stage and sets the format to
// fp32 passthrough, the zero point to 0 and the scale to 1.0.
// Depends on tedq_pkg and the stage modules tedq_front, tedq_mul, tedq_norm, tedq_round.
module tensor_element_dequantizer
    import tedq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] raw_element,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value_bits
);

    // Configuration registers. Writes are always taken; an index past the
    // register list is dropped. Only the decode stage reads them.
    tedq_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.element_format <= FMT_FP32;
            cfg_reg.zero_point     <= 9'sd0;
            cfg_reg.scale_bits     <= SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FORMAT:     cfg_reg.element_format <= cfg_data[2:0];
                REG_ZERO_POINT: cfg_reg.zero_point     <= $signed(cfg_data[8:0]);
                REG_SCALE:      cfg_reg.scale_bits     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Stage chain. Each stage's ready depends only on its own valid bit and the
    // ready of the stage after it, so a stall holds every element in place.
    logic     s1_valid, s1_ready;
    logic     s2_valid, s2_ready;
    logic     s3_valid, s3_ready;
    tedq_s1_t s1_data;
    tedq_s2_t s2_data;
    tedq_s3_t s3_data;

    // Decode: format select, exact integer difference, NaN and infinity scales.
    tedq_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .raw_element (raw_element),
        .out_valid   (s1_valid),
        .out_ready   (s1_ready),
        .out_data    (s1_data)
    );

    // Product of the difference magnitude and the scale significand.
    tedq_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // Leading one search and shift amount.
    tedq_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    // Rounding and packing into the output register.
    tedq_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s3_valid),
        .in_ready   (s3_ready),
        .in_data    (s3_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value_bits (value_bits)
    );

endmodule

FILE: sv/tedq_checker.sv
// Port-level checker for the tensor element dequantizer and its bind statement.
// Depends on the top level's port list only.
module tedq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] value_bits
);

    // A waiting result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_bits))
        else $error("result changed while stalled");

    // With the output register empty the whole pipeline can take a request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty pipeline");

    // Right after reset no result appears before a request could have passed through every stage.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid)
        else $error("result appeared too soon after reset");

    // Configuration writes are never back-pressured.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind tensor_element_dequantizer tedq_checker u_tedq_checker (.*);
